// ===== design/lcam_pkg.sv =====
// Shared constants, opcode and stage control types and a helper function for the linear classifier.
package lcam_pkg;

	localparam int VALUE_W      = 16;
	localparam int LABEL_W      = 32;
	localparam int ACC_W        = 40;
	localparam int OPCODE_W     = 2;
	localparam int CLASS_SLOT_W = 4;
	localparam int FEAT_SLOT_W  = 6;
	localparam int ROWS_W       = 5;

	localparam int MAX_CLASSES_DEF  = 16;
	localparam int MAX_FEATURES_DEF = 64;
	localparam int FEATURE_BITS_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;

	// Operation codes carried on the opcode field of an input transfer.
	typedef enum logic [OPCODE_W-1:0] {
		OP_WEIGHT   = 2'd0,
		OP_LABEL    = 2'd1,
		OP_FEATURE  = 2'd2,
		OP_RESERVED = 2'd3
	} lcam_op_t;

	// Control bits that travel with a feature down the multiply/accumulate stages.
	typedef struct packed {
		logic valid;
		logic acc;
		logic last;
	} lcam_ctl_t;

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

endpackage

// ===== design/lcam_lane.sv =====
// One class row: weight bank, feature-times-weight multiplier and saturating accumulator.
module lcam_lane import lcam_pkg::*; #(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF,
	parameter int FEATURE_BITS = FEATURE_BITS_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
	localparam int FW = min_int(FEATURE_BITS, VALUE_W),
	localparam int WW = min_int(WEIGHT_BITS, VALUE_W),
	localparam int FA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    wr_en,
	input  logic [FA-1:0]           wr_addr,
	input  logic signed [WW-1:0]    wr_data,
	input  logic [FA-1:0]           rd_addr,
	input  logic signed [FW-1:0]    feat_s1,
	input  lcam_ctl_t               ctl_s2,
	output logic signed [ACC_W-1:0] final_s3
);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [WW-1:0]    mem [MAX_FEATURES];
	logic signed [WW-1:0]    w_s1;
	logic signed [FW+WW-1:0] prod_s2;
	logic signed [ACC_W-1:0] sum_q;
	logic signed [ACC_W-1:0] sum_nxt;
	logic signed [ACC_W:0]   ext;

	// Weight bank: one write port from the input side, one registered read per feature.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (adv) begin
			w_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= feat_s1 * w_s1;
		end
	end

	always_comb begin
		ext = (ACC_W+1)'(sum_q) + (ACC_W+1)'(prod_s2);
		sum_nxt = sum_q;
		if (ctl_s2.acc) begin
			if (ext[ACC_W] != ext[ACC_W-1]) begin
				sum_nxt = ext[ACC_W] ? ACC_MIN : ACC_MAX;
			end else begin
				sum_nxt = ext[ACC_W-1:0];
			end
		end
	end

	// The running sum clears on the last feature; the finished sum moves to final_s3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && ctl_s2.valid) begin
			sum_q <= ctl_s2.last ? '0 : sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid) begin
			final_s3 <= sum_nxt;
		end
	end

endmodule

// ===== design/lcam_argmax.sv =====
// Registered comparison tree that finds the lowest-indexed maximum of the class sums.
module lcam_argmax import lcam_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF,
	localparam int LVL = $clog2(MAX_CLASSES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  logic signed [ACC_W-1:0] leaf_val [MAX_CLASSES],
	input  logic                    leaf_vld [MAX_CLASSES],
	output logic                    out_valid,
	output logic [LVL-1:0]          out_idx
);

	localparam int P  = 1 << LVL;
	localparam int NI = P - 1;
	localparam int NN = 2 * P - 1;

	// Heap layout: internal nodes 0..NI-1 are registered, leaves follow them.
	logic signed [ACC_W-1:0] nv [NN];
	logic [LVL-1:0]          ni [NN];
	logic                    nvl [NN];

	logic signed [ACC_W-1:0] val_q [NI];
	logic [LVL-1:0]          idx_q [NI];
	logic                    vld_q [NI];
	logic                    rv_q  [LVL];

	genvar g;
	generate
		for (g = 0; g < P; g++) begin : g_leaf
			if (g < MAX_CLASSES) begin : g_used
				assign nv[NI+g]  = leaf_val[g];
				assign nvl[NI+g] = leaf_vld[g];
			end else begin : g_pad
				assign nv[NI+g]  = '0;
				assign nvl[NI+g] = 1'b0;
			end
			assign ni[NI+g] = LVL'(g);
		end

		for (g = 0; g < NI; g++) begin : g_node
			localparam int A = 2 * g + 1;
			localparam int B = 2 * g + 2;
			logic pick_b;

			assign nv[g]  = val_q[g];
			assign ni[g]  = idx_q[g];
			assign nvl[g] = vld_q[g];

			// The higher index wins only when strictly larger or when the lower index is not valid.
			assign pick_b = nvl[B] && (!nvl[A] || (nv[B] > nv[A]));

			always_ff @(posedge clk) begin
				if (adv) begin
					val_q[g] <= pick_b ? nv[B] : nv[A];
					idx_q[g] <= pick_b ? ni[B] : ni[A];
					vld_q[g] <= nvl[A] || nvl[B];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LVL; k++) begin
				rv_q[k] <= 1'b0;
			end
		end else if (adv) begin
			rv_q[0] <= in_valid;
			for (int k = 1; k < LVL; k++) begin
				rv_q[k] <= rv_q[k-1];
			end
		end
	end

	assign out_valid = rv_q[LVL-1];
	assign out_idx   = ni[0];

endmodule

// ===== design/linear_classifier_argmax.sv =====
// Top level of the one-vs-rest logistic regression classifier with argmax output.
//
// The block takes one input transfer per clock cycle while item_stall is low. A
// transfer either writes a Q4.12 weight into a class row, writes the user label of
// a class, or carries one Q8.8 feature of a sample. All class rows multiply the
// feature by their own weight at the current feature position in parallel and add
// the product into a 40-bit saturating sum. The transfer flagged last ends the
// sample and produces exactly one result transfer: the winning class index and its
// user label. With class_rows at one, class 1 wins when the single sum is above
// zero and class 0 otherwise; with more rows the largest sum wins, lowest index on
// a tie. Features past MAX_FEATURES in a sample are ignored.
// The pipeline is one weight-bank read stage, one multiply stage, one
// accumulate stage, clog2(MAX_CLASSES) compare-tree stages and the result
// register. The sustained rate is one item per cycle while no result is held
// by result_stall, set by the single read port of each class's weight bank.
// The whole pipeline moves together; item_stall is raised only while a
// finished result is held in the result register by result_stall.
// Label writes are delayed to line up with the result register, so a label
// written after a sample's last feature never affects that sample's result.
// class_rows is written through class_rows_we and must only change while the
// block is idle. Weights and labels have no reset value and must be written
// before use.
module linear_classifier_argmax import lcam_pkg::*; #(
	parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
	parameter int MAX_FEATURES = MAX_FEATURES_DEF,
	parameter int FEATURE_BITS = FEATURE_BITS_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      class_rows_we,
	input  logic [ROWS_W-1:0]         class_rows,

	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [OPCODE_W-1:0]       opcode,
	input  logic [CLASS_SLOT_W-1:0]   class_slot,
	input  logic [FEAT_SLOT_W-1:0]    feature_slot,
	input  logic signed [VALUE_W-1:0] value,
	input  logic signed [LABEL_W-1:0] user_label,
	input  logic                      last,

	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [LABEL_W-1:0] predicted_label,
	output logic [CLASS_SLOT_W-1:0]   class_index
);

	localparam int FW   = min_int(FEATURE_BITS, VALUE_W);
	localparam int WW   = min_int(WEIGHT_BITS, VALUE_W);
	localparam int FA   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FC_W = $clog2(MAX_FEATURES + 1);
	localparam int LVL  = $clog2(MAX_CLASSES);
	// Label writes travel this many stages so they land in order with results.
	localparam int LD   = LVL + 2;

	logic                    adv;
	logic                    accept;
	logic                    is_weight;
	logic                    is_label;
	logic                    is_feature;
	logic                    rows1;

	logic [ROWS_W-1:0]       class_rows_q;
	logic [FC_W-1:0]         fc_q;

	lcam_ctl_t               ctl_in;
	lcam_ctl_t               ctl_s1;
	lcam_ctl_t               ctl_s2;
	logic                    res_s3;
	logic signed [FW-1:0]    feat_s1;

	logic                    wr_en [MAX_CLASSES];
	logic signed [ACC_W-1:0] fin_s3 [MAX_CLASSES];
	logic signed [ACC_W-1:0] leaf_val [MAX_CLASSES];
	logic                    leaf_vld [MAX_CLASSES];

	logic                    root_valid;
	logic [LVL-1:0]          root_idx;

	logic signed [LABEL_W-1:0] label_q [MAX_CLASSES];
	logic                      lw_vld_q  [LD];
	logic [LVL-1:0]            lw_slot_q [LD];
	logic signed [LABEL_W-1:0] lw_data_q [LD];

	logic                      result_valid_q;
	logic signed [LABEL_W-1:0] predicted_label_q;
	logic [CLASS_SLOT_W-1:0]   class_index_q;

	// The pipeline holds only while a finished result is waiting downstream.
	assign adv        = !(result_valid_q && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;

	always_comb begin
		is_weight  = 1'b0;
		is_label   = 1'b0;
		is_feature = 1'b0;
		case (lcam_op_t'(opcode))
			OP_WEIGHT:  is_weight  = 1'b1;
			OP_LABEL:   is_label   = 1'b1;
			OP_FEATURE: is_feature = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_rows_q <= ROWS_W'(1);
		end else if (class_rows_we) begin
			class_rows_q <= class_rows;
		end
	end

	// Feature position within the current sample; it saturates at MAX_FEATURES.
	always_comb begin
		ctl_in.valid = accept && is_feature;
		ctl_in.acc   = int'(fc_q) < MAX_FEATURES;
		ctl_in.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else if (ctl_in.valid) begin
			if (last) begin
				fc_q <= '0;
			end else if (ctl_in.acc) begin
				fc_q <= fc_q + FC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			res_s3 <= 1'b0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			res_s3 <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			feat_s1 <= value[FW-1:0];
		end
	end

	// Weight writes go straight into the addressed class bank.
	always_comb begin
		for (int c = 0; c < MAX_CLASSES; c++) begin
			wr_en[c] = accept && is_weight && (int'(feature_slot) < MAX_FEATURES)
				&& (int'(class_slot) == c);
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_CLASSES; g++) begin : g_lane
			lcam_lane #(
				.MAX_FEATURES (MAX_FEATURES),
				.FEATURE_BITS (FEATURE_BITS),
				.WEIGHT_BITS  (WEIGHT_BITS)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.wr_en    (wr_en[g]),
				.wr_addr  (FA'(feature_slot)),
				.wr_data  (value[WW-1:0]),
				.rd_addr  (fc_q[FA-1:0]),
				.feat_s1  (feat_s1),
				.ctl_s2   (ctl_s2),
				.final_s3 (fin_s3[g])
			);
		end
	endgenerate

	// In binary mode the tree compares a constant zero at index 0 against the
	// single sum at index 1, so class 1 wins only when the sum is above zero.
	assign rows1 = class_rows_q <= ROWS_W'(1);

	always_comb begin
		for (int c = 0; c < MAX_CLASSES; c++) begin
			leaf_val[c] = fin_s3[c];
			leaf_vld[c] = c < int'(class_rows_q);
		end
		if (rows1) begin
			for (int c = 0; c < MAX_CLASSES; c++) begin
				leaf_vld[c] = c < 2;
			end
			leaf_val[0] = '0;
			leaf_val[1] = fin_s3[0];
		end
	end

	lcam_argmax #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_argmax (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (res_s3),
		.leaf_val  (leaf_val),
		.leaf_vld  (leaf_vld),
		.out_valid (root_valid),
		.out_idx   (root_idx)
	);

	// Delay line for label writes, applied at the edge where results read the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LD; k++) begin
				lw_vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			lw_vld_q[0] <= accept && is_label && (int'(class_slot) < MAX_CLASSES);
			for (int k = 1; k < LD; k++) begin
				lw_vld_q[k] <= lw_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lw_slot_q[0] <= LVL'(class_slot);
			lw_data_q[0] <= user_label;
			for (int k = 1; k < LD; k++) begin
				lw_slot_q[k] <= lw_slot_q[k-1];
				lw_data_q[k] <= lw_data_q[k-1];
			end
			if (lw_vld_q[LD-1]) begin
				label_q[lw_slot_q[LD-1]] <= lw_data_q[LD-1];
			end
		end
	end

	// Result register: a held result stalls the pipeline until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= root_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && root_valid) begin
			predicted_label_q <= label_q[root_idx];
			class_index_q     <= CLASS_SLOT_W'(root_idx);
		end
	end

	assign result_valid    = result_valid_q;
	assign predicted_label = predicted_label_q;
	assign class_index     = class_index_q;

endmodule
